>>> hdl/decimal_long_division_rounder_assert.svh
// assertion macros for the decimal long division rounder back end
// depends on nothing; included by dldr_back, the only file that carries assertions
`ifndef DECIMAL_LONG_DIVISION_ROUNDER_ASSERT_SVH
`define DECIMAL_LONG_DIVISION_ROUNDER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DLDR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dldr check failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define DLDR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dldr check failed: next-cycle implication");

`endif

>>> hdl/dldr_pkg.sv
// shared types and constants for the decimal long division rounder
// no dependencies
`timescale 1ns / 1ps

package dldr_pkg;

  localparam int DATA_W         = 32;
  localparam int CNT_W          = 6;
  localparam int DIGIT_W        = 4;
  localparam int KIND_W         = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 6;
  localparam int MAX_DIGITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CNT_W-1:0] DIGIT_COUNT_RST = 6'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_EN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ZEROS  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_INT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DIGIT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR   = 2'd2;

  // classified division job handed from front to back
  typedef struct packed {
    logic              err;
    logic              neg;
    logic [DATA_W-1:0] amag;
    logic [DATA_W-1:0] bmag;
    logic [CNT_W-1:0]  n;
    logic              round_en;
    logic              keep;
  } job_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               negative;
    logic [DATA_W-1:0]  integer_magnitude;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } item_t;

endpackage

>>> hdl/dldr_intf.sv
// valid/ready channel interfaces for operand and result items
// depends on dldr_pkg
`timescale 1ns / 1ps

interface dldr_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [dldr_pkg::DATA_W-1:0] dividend;
  logic signed [dldr_pkg::DATA_W-1:0] divisor;

  modport source (output valid, dividend, divisor, input ready);
  modport sink (input valid, dividend, divisor, output ready);
endinterface

interface dldr_out_if;
  logic                             valid;
  logic                             ready;
  logic [dldr_pkg::KIND_W-1:0]      kind;
  logic                             negative;
  logic [dldr_pkg::DATA_W-1:0]      integer_magnitude;
  logic [dldr_pkg::DIGIT_W-1:0]     digit;
  logic                             last;

  modport source (output valid, kind, negative, integer_magnitude, digit, last, input ready);
  modport sink (input valid, kind, negative, integer_magnitude, digit, last, output ready);
endinterface

>>> hdl/dldr_front.sv
// front end: configuration registers, operand accept and classification
// depends on dldr_pkg and dldr_intf
`timescale 1ns / 1ps

module dldr_front #(
  parameter int MAX_DIGITS = dldr_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  dldr_in_if.sink                         in_i,
  input  logic                            cfg_we_i,
  input  logic [dldr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dldr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output dldr_pkg::job_t                  job_o
);

  logic [dldr_pkg::CNT_W-1:0] digit_count_q;
  logic                       round_en_q;
  logic                       keep_q;

  logic [dldr_pkg::DATA_W-1:0] a_u;
  logic [dldr_pkg::DATA_W-1:0] b_u;
  logic                        a_neg;
  logic                        b_neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q <= dldr_pkg::DIGIT_COUNT_RST;
      round_en_q    <= 1'b0;
      keep_q        <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dldr_pkg::CFG_DIGIT_COUNT: digit_count_q <= cfg_data_i[dldr_pkg::CNT_W-1:0];
        dldr_pkg::CFG_ROUND_EN:    round_en_q    <= cfg_data_i[0];
        dldr_pkg::CFG_KEEP_ZEROS:  keep_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign a_u   = in_i.dividend;
  assign b_u   = in_i.divisor;
  assign a_neg = a_u[dldr_pkg::DATA_W-1];
  assign b_neg = b_u[dldr_pkg::DATA_W-1];

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  always_comb begin
    job_o.err  = (b_u == '0);
    job_o.neg  = (a_neg != b_neg) && (a_u != '0);
    // two's complement negate also covers the most negative value
    job_o.amag = a_neg ? (~a_u + 1'b1) : a_u;
    job_o.bmag = b_neg ? (~b_u + 1'b1) : b_u;
    job_o.n    = (digit_count_q > dldr_pkg::CNT_W'(MAX_DIGITS))
                 ? dldr_pkg::CNT_W'(MAX_DIGITS) : digit_count_q;
    job_o.round_en = round_en_q;
    job_o.keep     = keep_q;
  end

endmodule

>>> hdl/dldr_queue.sv
// short job queue between the front end and the divider back end
// depends on dldr_pkg
`timescale 1ns / 1ps

module dldr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dldr_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output dldr_pkg::job_t job_o
);

  localparam int Depth = dldr_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  dldr_pkg::job_t      slots_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign job_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> hdl/dldr_back.sv
// back end: integer divide, digit generation, rounding and result output
// depends on dldr_pkg, dldr_intf and the assertion macro header
`timescale 1ns / 1ps
`include "decimal_long_division_rounder_assert.svh"

module dldr_back #(
  parameter int MAX_DIGITS = dldr_pkg::MAX_DIGITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  dldr_pkg::job_t job_i,
  output logic           job_pop_o,
  dldr_out_if.source     out_o
);

  localparam int DW = dldr_pkg::DATA_W;
  localparam int CW = dldr_pkg::CNT_W;
  localparam int GW = dldr_pkg::DIGIT_W;
  localparam int RW = DW + 3;  // remainder times ten
  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INT      = 3'd1;
  localparam logic [2:0] S_DIG      = 3'd2;
  localparam logic [2:0] S_EMIT_INT = 3'd3;
  localparam logic [2:0] S_EMIT_DIG = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [1:0]    sub_q, sub_d;
  logic [2:0]    dbits_q, dbits_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] lnz_q, lnz_d;
  logic          has_nz_q, has_nz_d;
  logic [GW-1:0] extra_q, extra_d;
  logic          neg_q, neg_d;
  logic          round_q, round_d;
  logic          keep_q, keep_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [DW-1:0] bmag_q, bmag_d;
  logic [RW-1:0] rem_q, rem_d;

  logic [GW-1:0] mem_q [MAX_DIGITS];
  logic [GW-1:0] rdata_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [GW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  dldr_pkg::item_t out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic            out_load;
  logic            out_free;

  // datapath helpers
  logic [DW:0]   rem_sh;
  logic          int_ge;
  logic [RW-1:0] rem10;
  logic [RW-1:0] dsrc;
  logic [RW-1:0] bsh;
  logic          dig_ge;
  logic [RW-1:0] dnext;
  logic [GW-1:0] dval;
  logic          round_up;
  logic [GW-1:0] emit_digit;
  logic [CW-1:0] idx_inc;

  assign out_free = !out_valid_q || out_o.ready;
  assign round_up = round_q && (extra_q > GW'(4));
  assign idx_inc  = idx_q + 1'b1;

  always_comb begin
    rem_sh = {rem_q[DW-1:0], quo_q[DW-1]};
    int_ge = (rem_sh >= {1'b0, bmag_q});
    rem10  = ({3'b000, rem_q[DW-1:0]} << 3) + ({3'b000, rem_q[DW-1:0]} << 1);
    dsrc   = (sub_q == 2'd0) ? rem10 : rem_q;
    bsh    = {3'b000, bmag_q} << (2'd3 - sub_q);
    dig_ge = (dsrc >= bsh);
    dnext  = dig_ge ? (dsrc - bsh) : dsrc;
    dval   = {dbits_q, dig_ge};
  end

  // rounding applied on the way out: digits past the last non-nine clear,
  // that digit steps up, with no non-nine the carry lands in the integer
  always_comb begin
    emit_digit = rdata_q;
    if (round_up) begin
      if (!has_nz_q || (idx_q > lnz_q)) begin
        emit_digit = '0;
      end else if (idx_q == lnz_q) begin
        emit_digit = rdata_q + 1'b1;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    sub_d     = sub_q;
    dbits_d   = dbits_q;
    idx_d     = idx_q;
    n_d       = n_q;
    lnz_d     = lnz_q;
    has_nz_d  = has_nz_q;
    extra_d   = extra_q;
    neg_d     = neg_q;
    round_d   = round_q;
    keep_d    = keep_q;
    quo_d     = quo_q;
    bmag_d    = bmag_q;
    rem_d     = rem_q;
    job_pop_o = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = idx_q[AW-1:0];
    wr_data   = dval;
    rd_en     = 1'b0;
    rd_addr   = '0;
    out_load  = 1'b0;
    out_d     = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          if (job_i.err) begin
            if (out_free) begin
              job_pop_o = 1'b1;
              out_load  = 1'b1;
              out_d     = '{kind: dldr_pkg::KIND_ERR, negative: 1'b0,
                            integer_magnitude: '0, digit: '0, last: 1'b1};
            end
          end else begin
            job_pop_o = 1'b1;
            neg_d     = job_i.neg;
            round_d   = job_i.round_en;
            keep_d    = job_i.keep;
            n_d       = job_i.n;
            quo_d     = job_i.amag;
            bmag_d    = job_i.bmag;
            rem_d     = '0;
            cnt_d     = '0;
            has_nz_d  = 1'b0;
            lnz_d     = '0;
            extra_d   = '0;
            state_d   = S_INT;
          end
        end
      end

      S_INT: begin
        quo_d = {quo_q[DW-2:0], int_ge};
        rem_d = int_ge ? {2'b00, rem_sh - {1'b0, bmag_q}} : {2'b00, rem_sh};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          idx_d   = '0;
          sub_d   = '0;
          dbits_d = '0;
          state_d = S_DIG;
        end
      end

      S_DIG: begin
        rem_d   = dnext;
        sub_d   = sub_q + 1'b1;
        dbits_d = {dbits_q[1:0], dig_ge};
        if (sub_q == 2'd3) begin
          if (idx_q < n_q) begin
            wr_en = 1'b1;
            if (dval != GW'(9)) begin
              lnz_d    = idx_q;
              has_nz_d = 1'b1;
            end
          end else begin
            extra_d = dval;
          end
          if (!keep_q && (dnext == '0)) begin
            // exact end: keep digits so far; before the extra digit, no rounding
            if (idx_q != n_q) begin
              n_d     = idx_inc;
              extra_d = '0;
            end
            state_d = S_EMIT_INT;
          end else if (idx_q == n_q) begin
            state_d = S_EMIT_INT;
          end else begin
            idx_d = idx_inc;
          end
        end
      end

      S_EMIT_INT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{kind: dldr_pkg::KIND_INT, negative: neg_q,
                       integer_magnitude: quo_q + DW'(round_up && !has_nz_q),
                       digit: '0, last: (n_q == '0)};
          rd_en    = 1'b1;
          rd_addr  = '0;
          idx_d    = '0;
          state_d  = (n_q == '0) ? S_IDLE : S_EMIT_DIG;
        end
      end

      S_EMIT_DIG: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{kind: dldr_pkg::KIND_DIGIT, negative: 1'b0,
                       integer_magnitude: '0, digit: emit_digit,
                       last: (idx_inc == n_q)};
          idx_d    = idx_inc;
          if (idx_inc == n_q) begin
            state_d = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_inc[AW-1:0];
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      sub_q       <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      has_nz_q    <= 1'b0;
      extra_q     <= '0;
      round_q     <= 1'b0;
      keep_q      <= 1'b1;
      quo_q       <= '0;
      rem_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      sub_q       <= sub_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      has_nz_q    <= has_nz_d;
      extra_q     <= extra_d;
      round_q     <= round_d;
      keep_q      <= keep_d;
      quo_q       <= quo_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dbits_q <= dbits_d;
    lnz_q   <= lnz_d;
    neg_q   <= neg_d;
    bmag_q  <= bmag_d;
    out_q   <= out_d;
  end

  // digit store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.kind              = out_q.kind;
  assign out_o.negative          = out_q.negative;
  assign out_o.integer_magnitude = out_q.integer_magnitude;
  assign out_o.digit             = out_q.digit;
  assign out_o.last              = out_q.last;

  `DLDR_ASSERT_IMPL(a_digit_range, clk_i, rst_ni,
    out_valid_q && (out_q.kind == dldr_pkg::KIND_DIGIT), out_q.digit <= GW'(9))
  `DLDR_ASSERT_IMPL(a_err_single, clk_i, rst_ni,
    out_valid_q && (out_q.kind == dldr_pkg::KIND_ERR),
    out_q.last && (out_q.integer_magnitude == '0))
  `DLDR_ASSERT_IMPL(a_rem_below_div, clk_i, rst_ni,
    (state_q == S_DIG) && (sub_q == 2'd0), rem_q < {3'b000, bmag_q})
  `DLDR_ASSERT_NEXT(a_int_to_dig, clk_i, rst_ni,
    (state_q == S_INT) && (cnt_q == 5'd31), state_q == S_DIG)
  `DLDR_ASSERT_IMPL(a_emit_idx, clk_i, rst_ni,
    state_q == S_EMIT_DIG, idx_q < n_q)

endmodule

>>> hdl/decimal_long_division_rounder.sv
// top level: front end, job queue and divider back end
// depends on dldr_pkg, dldr_intf, dldr_front, dldr_queue, dldr_back
//
// channel    dir   handshake       payload
// in_i       in    valid/ready     dividend, divisor
// out_o      out   valid/ready     kind, negative, integer_magnitude, digit, last
// cfg        in    cfg_we_i        cfg_idx_i, cfg_data_i
//
// a division runs a bit-serial integer divide, then generates fraction digits
// over n + 1 digits (one quotient bit per cycle), then emits the integer and
// n digits; with keep zeros off a zero remainder ends the digits early
// a zero divisor yields a single error item; no clearing pass after reset
// a two-entry job queue lets operands transfer while the back end works or
// waits on a stalled output

`timescale 1ns / 1ps

module decimal_long_division_rounder #(
  parameter int MAX_DIGITS = dldr_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  dldr_in_if.sink                         in_i,
  dldr_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [dldr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dldr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic           q_full;
  logic           push;
  dldr_pkg::job_t push_job;
  logic           pop;
  logic           q_valid;
  dldr_pkg::job_t pop_job;

  dldr_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .job_o     (push_job)
  );

  dldr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .job_o  (pop_job)
  );

  dldr_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_i      (pop_job),
    .job_pop_o  (pop),
    .out_o      (out_o)
  );

endmodule
